FILE: rtl/core/dgbd_pkg.sv
`timescale 1ns / 1ps

package dgbd_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF     = 2048;
   localparam int WINDOW_RADIUS_DEF = 2;
   localparam int WEIGHT_BITS_DEF   = 16;

   localparam int MAX_HEIGHT = 2048;
   localparam int CFG_W      = 12;
   localparam int CSR_IDX_W  = 4;

   // Pixel word: red [7:0], green [15:8], blue [23:16], depth [43:24]
   localparam int CH_W    = 8;
   localparam int RGB_W   = 24;
   localparam int DEPTH_W = 20;
   localparam int PIX_W   = 44;

   // Weight datapath widths (cover radius up to 3)
   localparam int TAP_S_W = 5;
   localparam int V_W     = 18;
   localparam int DDC_W   = 13;
   localparam int Q_W     = 25;
   localparam int E_W     = 42;
   localparam int IP_W    = E_W - 32;
   localparam int TQ_W    = 25;
   localparam int TD_W    = 20;
   localparam int FR_W    = 16;
   localparam int PROD_W  = TD_W + FR_W;
   localparam int SH_W    = 11;

   localparam logic [DEPTH_W-1:0] DD_CAP  = 20'd4096;
   localparam logic [31:0]        K_SPACE = 32'd3098164009;
   localparam logic [23:0]        K_COLOR = 24'd10327213;
   localparam logic [16:0]        K_DEPTH = 17'd94643;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_WAIT,
      ST_DIV,
      ST_DONE
   } seq_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 4'd0,
      CSR_IMAGE_HEIGHT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic               vld;
      logic               ctr;
      logic [TAP_S_W-1:0] s;
   } tap_info_type;

   // 2^(-k/16) in Q24
   function automatic logic [TQ_W-1:0] pow2_neg_q24(input logic [4:0] idx);
      logic [TQ_W-1:0] val;
      case (idx)
         5'd0: val = 25'd16777216;
         5'd1: val = 25'd16065917;
         5'd2: val = 25'd15384775;
         5'd3: val = 25'd14732511;
         5'd4: val = 25'd14107901;
         5'd5: val = 25'd13509772;
         5'd6: val = 25'd12937002;
         5'd7: val = 25'd12388516;
         5'd8: val = 25'd11863283;
         5'd9: val = 25'd11360319;
         5'd10: val = 25'd10878679;
         5'd11: val = 25'd10417458;
         5'd12: val = 25'd9975792;
         5'd13: val = 25'd9552851;
         5'd14: val = 25'd9147842;
         5'd15: val = 25'd8760003;
         5'd16: val = 25'd8388608;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/core/dgbd_line_mem.sv
`timescale 1ns / 1ps

module dgbd_line_mem
   import dgbd_pkg::*;
#(
   parameter int DEPTH  = 6 * MAX_WIDTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [PIX_W-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [PIX_W-1:0]  rdata
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/dgbd_weight.sv
`timescale 1ns / 1ps

module dgbd_weight
   import dgbd_pkg::*;
#(
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int WT_W        = WEIGHT_BITS + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  tap_info_type     tap_in,
   input  logic [PIX_W-1:0] rd_data,
   output logic             wt_vld,
   output logic [WT_W-1:0]  wt,
   output logic [RGB_W-1:0] wt_rgb,
   output logic             busy
);

   localparam logic [SH_W-1:0] SH_BASE = SH_W'(24 - WEIGHT_BITS);

   // stage A: aligned with the memory read data
   tap_info_type     a_info_ff;
   logic [PIX_W-1:0] ctr_pix_ff;

   logic [V_W-1:0]     v_a;
   logic [Q_W-1:0]     q_a;
   logic [DEPTH_W-1:0] dd_a;
   logic [DDC_W-1:0]   ddc_a;
   logic [CH_W-1:0]    ca, cb, df;

   // stage B
   logic               b_vld_ff;
   logic [V_W-1:0]     v_b_ff;
   logic [Q_W-1:0]     q_b_ff;
   logic [TAP_S_W-1:0] s_b_ff;
   logic [RGB_W-1:0]   rgb_b_ff;

   // stage C
   logic             c_vld_ff;
   logic [E_W-1:0]   e_c_ff;
   logic [E_W-1:0]   e_in;
   logic [RGB_W-1:0] rgb_c_ff;

   // stage D
   logic              d_vld_ff;
   logic [TQ_W-1:0]   tk_d_ff;
   logic [PROD_W-1:0] prod_d_ff;
   logic [IP_W-1:0]   ip_d_ff;
   logic [RGB_W-1:0]  rgb_d_ff;

   logic [3:0]        k_c;
   logic [TQ_W-1:0]   tk_c, tk1_c;
   logic [TD_W-1:0]   diff_c;
   logic [PROD_W-1:0] prod_in;

   logic [TQ_W-1:0] m_d;
   logic [SH_W-1:0] sh_d;

   always_comb begin
      v_a = '0;
      for (int ch = 0; ch < 3; ch++) begin
         ca = ctr_pix_ff[CH_W*ch +: CH_W];
         cb = rd_data[CH_W*ch +: CH_W];
         df = (ca > cb) ? (ca - cb) : (cb - ca);
         v_a = v_a + V_W'(V_W'(df) * V_W'(df));
      end
      dd_a = (ctr_pix_ff[PIX_W-1:RGB_W] > rd_data[PIX_W-1:RGB_W]) ?
             (ctr_pix_ff[PIX_W-1:RGB_W] - rd_data[PIX_W-1:RGB_W]) :
             (rd_data[PIX_W-1:RGB_W] - ctr_pix_ff[PIX_W-1:RGB_W]);
      ddc_a = (dd_a > DD_CAP) ? DDC_W'(DD_CAP) : dd_a[DDC_W-1:0];
      q_a = Q_W'(ddc_a) * Q_W'(ddc_a);
   end

   assign e_in = E_W'(s_b_ff) * E_W'(K_SPACE) + E_W'(v_b_ff) * E_W'(K_COLOR)
               + E_W'(q_b_ff) * E_W'(K_DEPTH);

   always_comb begin
      k_c     = e_c_ff[31:28];
      tk_c    = pow2_neg_q24({1'b0, k_c});
      tk1_c   = pow2_neg_q24({1'b0, k_c} + 5'd1);
      diff_c  = TD_W'(tk_c - tk1_c);
      prod_in = PROD_W'(diff_c) * PROD_W'(e_c_ff[27:12]);
   end

   always_comb begin
      m_d  = tk_d_ff - TQ_W'(prod_d_ff[PROD_W-1:FR_W]);
      sh_d = SH_W'(ip_d_ff) + SH_BASE;
      wt   = (sh_d >= SH_W'(32)) ? '0 : WT_W'(m_d >> sh_d[4:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_info_ff <= '0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
      end else begin
         a_info_ff <= tap_in;
         b_vld_ff  <= a_info_ff.vld & ~a_info_ff.ctr;
         c_vld_ff  <= b_vld_ff;
         d_vld_ff  <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_info_ff.vld && a_info_ff.ctr) begin
         ctr_pix_ff <= rd_data;
      end
      v_b_ff    <= v_a;
      q_b_ff    <= q_a;
      s_b_ff    <= a_info_ff.s;
      rgb_b_ff  <= rd_data[RGB_W-1:0];
      e_c_ff    <= e_in;
      rgb_c_ff  <= rgb_b_ff;
      tk_d_ff   <= tk_c;
      prod_d_ff <= prod_in;
      ip_d_ff   <= e_c_ff[E_W-1:32];
      rgb_d_ff  <= rgb_c_ff;
   end

   assign wt_vld = d_vld_ff;
   assign wt_rgb = rgb_d_ff;
   assign busy   = a_info_ff.vld | b_vld_ff | c_vld_ff | d_vld_ff;

endmodule

FILE: rtl/core/dgbd_div.sv
`timescale 1ns / 1ps

module dgbd_div
   import dgbd_pkg::*;
#(
   parameter int TOT_W = 22,
   parameter int ACC_W = TOT_W + CH_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2:0][ACC_W-1:0]     acc,
   input  logic [TOT_W-1:0]          total,
   output logic                      busy,
   output logic [2:0][CH_W-1:0]      quo
);

   logic                    busy_ff;
   logic [2:0]              cnt_ff;
   logic                    zero_ff;
   logic [ACC_W-1:0]        den_ff;
   logic [2:0][ACC_W-1:0]   rem_ff;
   logic [2:0][CH_W-1:0]    quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // one quotient bit per cycle, three channels share the divisor
   always_ff @(posedge clock) begin
      if (start) begin
         zero_ff <= (total == '0);
         den_ff  <= ACC_W'(total) << (CH_W - 1);
         rem_ff  <= acc;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         den_ff <= den_ff >> 1;
         for (int ch = 0; ch < 3; ch++) begin
            if (rem_ff[ch] >= den_ff) begin
               rem_ff[ch] <= rem_ff[ch] - den_ff;
               quo_ff[ch] <= {quo_ff[ch][CH_W-2:0], 1'b1};
            end else begin
               quo_ff[ch] <= {quo_ff[ch][CH_W-2:0], 1'b0};
            end
         end
      end
   end

   assign busy = busy_ff;
   assign quo  = zero_ff ? '0 : quo_ff;

endmodule

FILE: rtl/core/depth_guided_bilateral_denoise.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Beat carries
// req_     | in        | req_valid/req_stall  | command, red, green, blue, depth
// rsp_     | out       | rsp_valid/rsp_stall  | out_red, out_green, out_blue, frame_end
// csr_     | in        | csr_valid/csr_ready  | csr_index, csr_wdata (width, height)
//
// A beat that yields no result passes accept and the readiness check. A beat
// that yields a result then reads its window, one window read per cycle from
// the single read port of the line store, and goes through a four-stage weight
// pipeline and a bit-serial divider. The output register frees the input side:
// the next beat is taken while a result still waits on rsp_stall. Reset is
// synchronous: it clears counters, the sequencer and valid flags, sets a frame
// of 640x480; data registers and the line store hold garbage until written.

module depth_guided_bilateral_denoise
   import dgbd_pkg::*;
#(
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
   parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF,
   parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [CH_W-1:0]      req_red,
   input  logic [CH_W-1:0]      req_green,
   input  logic [CH_W-1:0]      req_blue,
   input  logic [DEPTH_W-1:0]   req_depth,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CH_W-1:0]      rsp_out_red,
   output logic [CH_W-1:0]      rsp_out_green,
   output logic [CH_W-1:0]      rsp_out_blue,
   output logic                 rsp_frame_end,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int LINE_ROWS = 2 * WINDOW_RADIUS + 2;
   localparam int WIN_SIDE  = 2 * WINDOW_RADIUS + 1;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W     = ((WID_W > CFG_W) ? WID_W : CFG_W) + 1;
   localparam int ROW_W     = $clog2(LINE_ROWS);
   localparam int ADDR_W    = $clog2(LINE_ROWS * MAX_WIDTH);
   localparam int D_W       = $clog2(WINDOW_RADIUS + 1) + 1;
   localparam int WT_W      = WEIGHT_BITS + 1;
   localparam int TOT_W     = WT_W + $clog2(WIN_SIDE * WIN_SIDE);
   localparam int ACC_W     = TOT_W + CH_W;
   localparam int RECIP     = (1 << 16) / LINE_ROWS;
   localparam int HR_W      = 12;
   localparam int YS_W      = 13;

   // y mod LINE_ROWS by reciprocal multiply and one correction
   function automatic logic [ROW_W-1:0] row_slot(input logic [10:0] y);
      logic [27:0] prod;
      logic [10:0] qt;
      logic [11:0] rem;
      prod = 28'(y) * 28'(RECIP);
      qt   = prod[26:16];
      rem  = 12'(y) - 12'(12'(qt) * 12'(LINE_ROWS));
      if (rem >= 12'(LINE_ROWS)) begin
         rem = rem - 12'(LINE_ROWS);
      end
      return ROW_W'(rem);
   endfunction

   seq_state_type state_ff, state_in;

   logic [CFG_W-1:0] img_w_ff, img_h_ff;
   logic [COL_W-1:0] in_col_ff, out_col_ff;
   logic [HR_W-1:0]  in_row_ff;
   logic [10:0]      out_row_ff;

   logic                   ctr_phase_ff;
   logic signed [D_W-1:0]  dx_ff, dy_ff;

   logic [TOT_W-1:0]         tot_ff;
   logic [2:0][ACC_W-1:0]    acc_ff;

   logic                rsp_valid_ff;
   logic [CH_W-1:0]     rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                rsp_end_ff;

   // effective frame size
   logic [CMP_W-1:0] iw, eff_w, w_last;
   logic [HR_W-1:0]  eff_h, h_last;

   // sequencing strobes
   logic accept, pix_write, ready, start_win, issue, last_tap;
   logic div_start, out_free, load_rsp, frame_end;

   // window address generation
   logic signed [D_W-1:0]   dx_sel, dy_sel;
   logic signed [CMP_W:0]   xs;
   logic signed [YS_W-1:0]  ys;
   logic [COL_W-1:0]        x_tap;
   logic [10:0]             y_tap;
   logic [D_W-1:0]          dxa, dya;
   logic [ADDR_W-1:0]       waddr, raddr;
   logic [HR_W-1:0]         nr, nr_c;
   logic [CMP_W-1:0]        nc, nc_c, col_inc, ocol_inc;
   tap_info_type            tap_info;

   logic [PIX_W-1:0]        rd_data;
   logic                    wt_vld, wt_busy, div_busy;
   logic [WT_W-1:0]         wt;
   logic [RGB_W-1:0]        wt_rgb;
   logic [2:0][CH_W-1:0]    quo;

   always_comb begin
      iw     = CMP_W'(img_w_ff);
      eff_w  = (img_w_ff == '0) ? CMP_W'(1) :
               (iw > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : iw;
      w_last = eff_w - CMP_W'(1);
      eff_h  = (img_h_ff == '0) ? HR_W'(1) :
               (img_h_ff > HR_W'(MAX_HEIGHT)) ? HR_W'(MAX_HEIGHT) : img_h_ff;
      h_last = eff_h - HR_W'(1);
   end

   // output pixel is ready once the bottom-right pixel of its window is in
   always_comb begin
      nr    = HR_W'(out_row_ff) + HR_W'(WINDOW_RADIUS);
      nr_c  = (nr > h_last) ? h_last : nr;
      nc    = CMP_W'(out_col_ff) + CMP_W'(WINDOW_RADIUS);
      nc_c  = (nc > w_last) ? w_last : nc;
      ready = (in_row_ff > nr_c) ||
              ((in_row_ff == nr_c) && (CMP_W'(in_col_ff) > nc_c));
      frame_end = (HR_W'(out_row_ff) >= h_last) && (CMP_W'(out_col_ff) >= w_last);
      col_inc   = CMP_W'(in_col_ff) + CMP_W'(1);
      ocol_inc  = CMP_W'(out_col_ff) + CMP_W'(1);
   end

   // tap coordinates, clamped to the frame border
   always_comb begin
      dx_sel = ctr_phase_ff ? '0 : dx_ff;
      dy_sel = ctr_phase_ff ? '0 : dy_ff;
      xs = $signed({1'b0, CMP_W'(out_col_ff)}) + (CMP_W + 1)'(dx_sel);
      ys = $signed({2'b00, out_row_ff}) + YS_W'(dy_sel);
      if (xs < 0) begin
         x_tap = '0;
      end else if (xs > $signed({1'b0, w_last})) begin
         x_tap = COL_W'(w_last);
      end else begin
         x_tap = COL_W'(xs);
      end
      if (ys < 0) begin
         y_tap = '0;
      end else if (ys > $signed({1'b0, h_last})) begin
         y_tap = 11'(h_last);
      end else begin
         y_tap = 11'(ys);
      end
      raddr = ADDR_W'(row_slot(y_tap)) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_tap);
      waddr = ADDR_W'(row_slot(in_row_ff[10:0])) * ADDR_W'(MAX_WIDTH)
            + ADDR_W'(in_col_ff);
      dxa = (dx_ff < 0) ? D_W'(-dx_ff) : D_W'(dx_ff);
      dya = (dy_ff < 0) ? D_W'(-dy_ff) : D_W'(dy_ff);
      tap_info.vld = issue;
      tap_info.ctr = ctr_phase_ff;
      tap_info.s   = TAP_S_W'(dxa) * TAP_S_W'(dxa) + TAP_S_W'(dya) * TAP_S_W'(dya);
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ready ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            if (last_tap) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!wt_busy) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: strobes
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && (state_ff == ST_IDLE);
      pix_write = accept && !req_command && (in_row_ff < eff_h);
      start_win = (state_ff == ST_CHECK) && ready;
      issue     = (state_ff == ST_READ);
      last_tap  = issue && !ctr_phase_ff && (dx_ff == D_W'(WINDOW_RADIUS))
                  && (dy_ff == D_W'(WINDOW_RADIUS));
      div_start = (state_ff == ST_WAIT) && !wt_busy;
      out_free  = !rsp_valid_ff || !rsp_stall;
      load_rsp  = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration; to be written only between beats, which the block does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= CFG_W'(640);
         img_h_ff <= CFG_W'(480);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // raster counters: advance input on a stored pixel, output on a loaded result,
   // drop all four back to zero after the last pixel of the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (load_rsp) begin
         if (frame_end) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (ocol_inc >= eff_w) begin
            out_col_ff <= '0;
            out_row_ff <= out_row_ff + 11'd1;
         end else begin
            out_col_ff <= COL_W'(ocol_inc);
         end
      end else if (pix_write) begin
         if (col_inc >= eff_w) begin
            in_col_ff <= '0;
            in_row_ff <= in_row_ff + HR_W'(1);
         end else begin
            in_col_ff <= COL_W'(col_inc);
         end
      end
   end

   // window walk: centre pixel first, then taps in raster order
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_phase_ff <= 1'b0;
         dx_ff        <= '0;
         dy_ff        <= '0;
      end else if (start_win) begin
         ctr_phase_ff <= 1'b1;
         dx_ff        <= -D_W'(WINDOW_RADIUS);
         dy_ff        <= -D_W'(WINDOW_RADIUS);
      end else if (issue) begin
         if (ctr_phase_ff) begin
            ctr_phase_ff <= 1'b0;
         end else if (dx_ff == D_W'(WINDOW_RADIUS)) begin
            dx_ff <= -D_W'(WINDOW_RADIUS);
            dy_ff <= dy_ff + D_W'(1);
         end else begin
            dx_ff <= dx_ff + D_W'(1);
         end
      end
   end

   // weighted sums
   always_ff @(posedge clock) begin
      if (start_win) begin
         tot_ff <= '0;
         acc_ff <= '0;
      end else if (wt_vld) begin
         tot_ff <= tot_ff + TOT_W'(wt);
         for (int ch = 0; ch < 3; ch++) begin
            acc_ff[ch] <= acc_ff[ch] + ACC_W'(wt) * ACC_W'(wt_rgb[CH_W*ch +: CH_W]);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_red_ff   <= quo[0];
         rsp_green_ff <= quo[1];
         rsp_blue_ff  <= quo[2];
         rsp_end_ff   <= frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_frame_end = rsp_end_ff;

   dgbd_line_mem #(
      .DEPTH  (LINE_ROWS * MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_mem (
      .clock (clock),
      .we    (pix_write),
      .waddr (waddr),
      .wdata ({req_depth, req_blue, req_green, req_red}),
      .re    (issue),
      .raddr (raddr),
      .rdata (rd_data)
   );

   dgbd_weight #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .WT_W        (WT_W)
   ) u_weight (
      .clock   (clock),
      .reset   (reset),
      .tap_in  (tap_info),
      .rd_data (rd_data),
      .wt_vld  (wt_vld),
      .wt      (wt),
      .wt_rgb  (wt_rgb),
      .busy    (wt_busy)
   );

   dgbd_div #(
      .TOT_W (TOT_W),
      .ACC_W (ACC_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .acc   (acc_ff),
      .total (tot_ff),
      .busy  (div_busy),
      .quo   (quo)
   );

endmodule

FILE: rtl/core/dgbd_checker.sv
`timescale 1ns / 1ps

module dgbd_checker
   import dgbd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input logic [CH_W-1:0] rsp_out_red,
   input logic [CH_W-1:0] rsp_out_green,
   input logic [CH_W-1:0] rsp_out_blue,
   input logic            rsp_frame_end
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red) &&
      $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_frame_end))
      else $error("result beat changed while stalled");

   // reset leaves no result pending and the input open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // one beat at a time: the input closes right after an accepted beat
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat accepted back to back");

   // a result never appears in the cycle after a beat is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind depth_guided_bilateral_denoise dgbd_checker u_dgbd_checker (.*);
